>>> sv/ps2md_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ps2md_pkg;

  // Default cursor coordinate width.
  localparam int COORD_BITS_DEF = 12;

  // Configuration register indexes.
  localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [1:0] REG_WHEEL_MODE    = 2'd2;

  localparam int SIZE_BITS = 13;

  // Reset screen size and the matching centred cursor.
  localparam logic [SIZE_BITS-1:0] RESET_WIDTH  = 13'd1024;
  localparam logic [SIZE_BITS-1:0] RESET_HEIGHT = 13'd768;
  localparam int RESET_POS_X = 512;
  localparam int RESET_POS_Y = 384;

  // Bit positions within the packet header byte.
  localparam int HDR_LEFT   = 0;
  localparam int HDR_RIGHT  = 1;
  localparam int HDR_MIDDLE = 2;
  localparam int HDR_SYNC   = 3;
  localparam int HDR_XSIGN  = 4;
  localparam int HDR_YSIGN  = 5;
  localparam int HDR_XOVF   = 6;
  localparam int HDR_YOVF   = 7;

endpackage

`default_nettype wire

>>> sv/ps2_mouse_packet_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

// PS/2 mouse packet decoder. Bytes from the mouse enter as single transactions
// on the s_ side and are gathered into packets of three bytes, or four when
// wheel_mode is set (the fourth byte is counted and discarded). A packet whose
// header byte has bit 3 clear is dropped with no output; the byte counter just
// restarts. Every valid packet yields one transaction on the m_ side with the
// clamped cursor position, the three buttons and the left press, left release
// and right press edges measured against the previous valid packet. The block
// takes one byte per clock unless a held result stalls it: a byte is captured
// in an input register, then the packet counter, the position add and the
// screen clamp all run in one short step and write the output register. The
// output register decouples the sides, so a new byte is accepted while a
// result waits to be taken; input stalls only when a result is held and the
// input register is also occupied. Screen size and wheel mode come from the
// cfg_ port (index 0 width, 1 height, 2 wheel mode) and should only be
// changed while no bytes are in flight. A resize does not move the cursor
// until the next valid packet is decoded. After reset the cursor sits at
// (512, 384), the centre of a 1024x768 screen.

module ps2_mouse_packet_decoder
  import ps2md_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire                         clk,
  input  wire                         rst,
  // Byte stream from the mouse.
  input  wire                         s_tvalid,
  output logic                        s_tready,
  input  wire  [7:0]                  s_tdata,    // [7:0] data_byte
  // Decoded packets.
  output logic                        m_tvalid,
  input  wire                         m_tready,
  // From bit 0 up: cursor_x, cursor_y, left_button, right_button,
  // middle_button, left_press_edge, left_release_edge, right_press_edge,
  // zero fill to whole bytes.
  output logic [((2*COORD_BITS+6+7)/8)*8-1:0] m_tdata,
  // Configuration writes.
  input  wire                         cfg_valid,
  output logic                        cfg_ready,
  input  wire  [1:0]                  cfg_index,
  input  wire  [SIZE_BITS-1:0]        cfg_data
);

  localparam int FIELD_W = 2 * COORD_BITS + 6;
  localparam int OUT_W   = ((FIELD_W + 7) / 8) * 8;
  localparam int CMAX    = (1 << COORD_BITS) - 1;
  // Signed working width that holds any position, motion and clamp limit.
  localparam int WW      = ((COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS) + 2;

  localparam logic [COORD_BITS-1:0] POS_X_RST =
    COORD_BITS'((RESET_POS_X > CMAX) ? CMAX : RESET_POS_X);
  localparam logic [COORD_BITS-1:0] POS_Y_RST =
    COORD_BITS'((RESET_POS_Y > CMAX) ? CMAX : RESET_POS_Y);
  localparam logic signed [WW-1:0] CMAX_W = WW'(CMAX);

  // Configuration registers; writes are always taken.
  logic [SIZE_BITS-1:0] screen_width;
  logic [SIZE_BITS-1:0] screen_height;
  logic                 wheel_mode;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= RESET_WIDTH;
      screen_height <= RESET_HEIGHT;
      wheel_mode    <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        REG_SCREEN_HEIGHT: screen_height <= cfg_data;
        REG_WHEEL_MODE:    wheel_mode    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Input register.
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_advance;

  assign s1_advance = s1_valid && (!m_tvalid || m_tready);
  assign s_tready   = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      s1_byte <= s_tdata;
    end
  end

  // Packet state. The buttons of the previous valid packet are the held
  // buttons_now, so the edges are formed before it is overwritten.
  logic [7:0]            packet_bytes [3];
  logic [1:0]            byte_index;
  logic [COORD_BITS-1:0] pos_x;
  logic [COORD_BITS-1:0] pos_y;
  logic [2:0]            buttons_now;

  logic [1:0]            index_inc;
  logic                  pkt_done;
  logic                  pkt_good;
  logic [7:0]            hdr;
  logic [7:0]            byte_y;
  logic signed [WW-1:0]  dx;
  logic signed [WW-1:0]  dy;
  logic signed [WW-1:0]  sum_x;
  logic signed [WW-1:0]  sum_y;
  logic signed [WW-1:0]  lim_x;
  logic signed [WW-1:0]  lim_y;
  logic [COORD_BITS-1:0] pos_x_next;
  logic [COORD_BITS-1:0] pos_y_next;

  always_comb begin
    index_inc = byte_index + 2'd1;
    // The packet closes on the third byte, or on the fourth in wheel mode.
    pkt_done  = (index_inc == 2'd0) || (!wheel_mode && index_inc == 2'd3);
    hdr       = packet_bytes[0];
    // In three-byte mode the closing byte is the y motion byte itself.
    byte_y    = (byte_index == 2'd2) ? s1_byte : packet_bytes[2];
    pkt_good  = pkt_done && hdr[HDR_SYNC];

    // Nine-bit two's complement motion; an overflowed axis does not move.
    dx = hdr[HDR_XOVF] ? '0 : WW'($signed({hdr[HDR_XSIGN], packet_bytes[1]}));
    dy = hdr[HDR_YOVF] ? '0 : WW'($signed({hdr[HDR_YSIGN], byte_y}));

    sum_x = $signed(WW'(pos_x)) + dx;
    sum_y = $signed(WW'(pos_y)) - dy;

    // Clamp limit is size - 1, with a zero size acting as one, capped by the
    // coordinate range.
    lim_x = (screen_width == '0) ? '0 : $signed(WW'(screen_width)) - WW'(1);
    lim_y = (screen_height == '0) ? '0 : $signed(WW'(screen_height)) - WW'(1);
    if (lim_x > CMAX_W) lim_x = CMAX_W;
    if (lim_y > CMAX_W) lim_y = CMAX_W;

    if (sum_x < 0)          pos_x_next = '0;
    else if (sum_x > lim_x) pos_x_next = lim_x[COORD_BITS-1:0];
    else                    pos_x_next = sum_x[COORD_BITS-1:0];

    if (sum_y < 0)          pos_y_next = '0;
    else if (sum_y > lim_y) pos_y_next = lim_y[COORD_BITS-1:0];
    else                    pos_y_next = sum_y[COORD_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (s1_advance && byte_index != 2'd3) begin
      packet_bytes[byte_index] <= s1_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index  <= 2'd0;
      pos_x       <= POS_X_RST;
      pos_y       <= POS_Y_RST;
      buttons_now <= 3'b000;
    end else if (s1_advance) begin
      byte_index <= pkt_done ? 2'd0 : index_inc;
      if (pkt_good) begin
        pos_x       <= pos_x_next;
        pos_y       <= pos_y_next;
        buttons_now <= hdr[2:0];
      end
    end
  end

  // Output register.
  logic left_press;
  logic left_release;
  logic right_press;

  assign left_press   = hdr[HDR_LEFT] && !buttons_now[0];
  assign left_release = !hdr[HDR_LEFT] && buttons_now[0];
  assign right_press  = hdr[HDR_RIGHT] && !buttons_now[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= s1_advance && pkt_good;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && pkt_good) begin
      m_tdata <= OUT_W'({right_press, left_release, left_press,
                         hdr[HDR_MIDDLE], hdr[HDR_RIGHT], hdr[HDR_LEFT],
                         pos_y_next, pos_x_next});
    end
  end

endmodule

`default_nettype wire

>>> verif/tb_ps2_mouse_packet_decoder.sv
`timescale 1ns / 1ps

// Self-checking bench for the PS/2 mouse packet decoder. Mouse bytes are fed
// through the s_ stream from a queue, cursor reports are taken from the m_
// stream, and every report is compared field by field against a behavioral
// decoder that runs on the bytes as they are accepted.
module tb_ps2_mouse_packet_decoder;
  import ps2md_pkg::*;

  localparam int COORD_W = COORD_BITS_DEF;
  // Two coordinates plus six flag bits, padded to whole bytes.
  localparam int REPORT_W = 32;
  // Index with no register behind it; a write there must change nothing.
  localparam logic [1:0] REG_SPARE = 2'd3;
  // The decoder answers through its input and output registers, so this is
  // plenty for any byte still in flight to be absorbed.
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT = 200000;

  // Report layout from the lowest bit up: x, y, left, right, middle,
  // left press, left release, right press, zero fill.
  typedef struct packed {
    logic [1:0]         fill;
    logic               right_press;
    logic               left_release;
    logic               left_press;
    logic               middle;
    logic               right;
    logic               left;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } cursor_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [7:0]           s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [REPORT_W-1:0]  m_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [1:0]           cfg_index = '0;
  logic [SIZE_BITS-1:0] cfg_data = '0;

  ps2_mouse_packet_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bytes waiting to be sent, and the reports the decoder is expected to make.
  logic [7:0]     mouse_bytes[$];
  cursor_report_t pending_reports[$];

  // When set, neither side idles.
  logic steady = 1'b0;

  int mismatches = 0;
  int bytes_queued = 0;
  int bytes_taken = 0;
  int reports_seen = 0;
  int reg_writes = 0;
  int cycles = 0;

  // Shadow copy of the decoder state and its register settings.
  logic [7:0]           pkt_hold[3];
  logic [1:0]           byte_pos = '0;
  int                   cur_x = RESET_POS_X;
  int                   cur_y = RESET_POS_Y;
  logic [2:0]           btn_now = '0;
  logic [1:0]           btn_prev = '0;
  logic [SIZE_BITS-1:0] scr_w = RESET_WIDTH;
  logic [SIZE_BITS-1:0] scr_h = RESET_HEIGHT;
  logic                 wheel_on = 1'b0;

  // Largest coordinate a screen dimension allows; zero acts like one, and the
  // limit never exceeds what the coordinate width can hold.
  function automatic int clamp_limit(logic [SIZE_BITS-1:0] size);
    int lim;
    lim = (size == 0) ? 0 : int'(size) - 1;
    return (lim > (1 << COORD_W) - 1) ? (1 << COORD_W) - 1 : lim;
  endfunction

  function automatic int clamp_coord(int v, int lim);
    if (v < 0) return 0;
    if (v > lim) return lim;
    return v;
  endfunction

  // Nine-bit two's complement motion, forced to zero when the axis overflowed.
  function automatic int motion_of(logic [7:0] low, logic neg, logic ovf);
    if (ovf) return 0;
    return neg ? int'(low) - 256 : int'(low);
  endfunction

  // Advances the shadow decoder by one accepted byte and queues the report
  // that a completed valid packet produces.
  task automatic decode_byte(input logic [7:0] b);
    logic [7:0]     hdr;
    int             need;
    cursor_report_t r;
    need = wheel_on ? 4 : 3;
    // The wheel byte is counted but never stored.
    if (byte_pos < 2'd3) pkt_hold[byte_pos] = b;
    byte_pos = byte_pos + 2'd1;
    if (byte_pos != 2'd0 && int'(byte_pos) < need) return;
    byte_pos = 2'd0;
    hdr = pkt_hold[0];
    // Without the sync bit the whole packet is thrown away, history included.
    if (!hdr[HDR_SYNC]) return;
    btn_prev = btn_now[1:0];
    btn_now = hdr[HDR_MIDDLE:HDR_LEFT];
    cur_x = clamp_coord(cur_x + motion_of(pkt_hold[1], hdr[HDR_XSIGN], hdr[HDR_XOVF]),
                        clamp_limit(scr_w));
    // Mouse y grows upward, screen rows grow downward.
    cur_y = clamp_coord(cur_y - motion_of(pkt_hold[2], hdr[HDR_YSIGN], hdr[HDR_YOVF]),
                        clamp_limit(scr_h));
    r = '0;
    r.x = cur_x[COORD_W-1:0];
    r.y = cur_y[COORD_W-1:0];
    r.left = btn_now[HDR_LEFT];
    r.right = btn_now[HDR_RIGHT];
    r.middle = btn_now[HDR_MIDDLE];
    r.left_press = btn_now[HDR_LEFT] & ~btn_prev[HDR_LEFT];
    r.left_release = ~btn_now[HDR_LEFT] & btn_prev[HDR_LEFT];
    r.right_press = btn_now[HDR_RIGHT] & ~btn_prev[HDR_RIGHT];
    pending_reports.push_back(r);
  endtask

  function automatic void check_field(string name, int exp_v, int got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      mismatches++;
    end
  endfunction

  // Byte driver. A new byte is offered only once the previous transaction has
  // completed, so the data never changes under a pending handshake.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (mouse_bytes.size() != 0 && (steady || $urandom_range(99) >= 36)) begin
        s_tvalid <= 1'b1;
        s_tdata <= mouse_bytes.pop_front();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Report consumer with random back-pressure.
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= steady || ($urandom_range(99) >= 36);
  end

  // Monitor. A report accepted at this edge can never come from the byte
  // accepted at the same edge, so it is checked before the byte is decoded.
  always @(posedge clk) begin
    cursor_report_t got;
    cursor_report_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (pending_reports.size() == 0) begin
          $error("unexpected cursor report: x %0d, y %0d", got.x, got.y);
          mismatches++;
        end else begin
          want = pending_reports.pop_front();
          check_field("cursor_x", want.x, got.x);
          check_field("cursor_y", want.y, got.y);
          check_field("left_button", want.left, got.left);
          check_field("right_button", want.right, got.right);
          check_field("middle_button", want.middle, got.middle);
          check_field("left_press_edge", want.left_press, got.left_press);
          check_field("left_release_edge", want.left_release, got.left_release);
          check_field("right_press_edge", want.right_press, got.right_press);
          check_field("fill", want.fill, got.fill);
          reports_seen++;
        end
      end
      if (s_tvalid && s_tready) begin
        decode_byte(s_tdata);
        bytes_taken++;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d reports outstanding.",
               cycles, pending_reports.size());
      $display("FAIL");
      $finish;
    end
  end

  // Holds the sender off until every byte is taken and every report is back,
  // then leaves time for a byte that closes a dropped packet to drain out.
  task automatic settle();
    do @(negedge clk);
    while (mouse_bytes.size() != 0 || s_tvalid || pending_reports.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [SIZE_BITS-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk);
    while (!(cfg_valid && cfg_ready));
    case (idx)
      REG_SCREEN_WIDTH:  scr_w = val;
      REG_SCREEN_HEIGHT: scr_h = val;
      REG_WHEEL_MODE:    wheel_on = val[0];
      default: ;
    endcase
    reg_writes++;
    cfg_valid <= 1'b0;
  endtask

  function automatic void queue_byte(input logic [7:0] b);
    mouse_bytes.push_back(b);
    bytes_queued++;
  endfunction

  // One packet of the current size; in wheel mode a random wheel byte follows.
  function automatic void push_packet(input logic [7:0] hdr, input logic [7:0] dx,
                                      input logic [7:0] dy);
    queue_byte(hdr);
    queue_byte(dx);
    queue_byte(dy);
    if (wheel_on) queue_byte(8'($urandom_range(255)));
  endfunction

  // Screen dimension drawn from the edges of the register range and beyond.
  function automatic logic [SIZE_BITS-1:0] pick_size();
    case ($urandom_range(7))
      0: return '0;
      1: return 13'd1;
      2: return 13'd4096;
      3: return 13'h1FFF;
      4: return 13'($urandom_range(64, 1));
      default: return 13'($urandom_range(4096, 16));
    endcase
  endfunction

  // Mostly well-formed packets with random content. Some carry a header with
  // the sync bit clear, and some are cut short: the decoder then frames the
  // following packets wrongly until filler bytes bring the count back.
  task automatic random_burst(input int count);
    int         stop;
    int         cut;
    int         plen;
    logic [7:0] hdr;
    stop = bytes_queued + count;
    while (bytes_queued < stop) begin
      plen = wheel_on ? 4 : 3;
      hdr = 8'($urandom_range(255));
      hdr[HDR_SYNC] = 1'b1;
      if ($urandom_range(3) != 0) hdr[HDR_YOVF:HDR_XOVF] = 2'b00;
      case ($urandom_range(19))
        0, 1: begin
          hdr[HDR_SYNC] = 1'b0;
          push_packet(hdr, 8'($urandom_range(255)), 8'($urandom_range(255)));
        end
        2: begin
          cut = $urandom_range(plen - 1, 1);
          repeat (cut) queue_byte(8'($urandom_range(255)));
          repeat ($urandom_range(2))
            push_packet(hdr, 8'($urandom_range(255)), 8'($urandom_range(255)));
          repeat (plen - cut) queue_byte(8'($urandom_range(255)));
        end
        default: push_packet(hdr, 8'($urandom_range(255)), 8'($urandom_range(255)));
      endcase
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset screen, three-byte packets. Full positive motion with a left
    // press, full negative motion with right press and left release, a header
    // missing its sync bit, and an overflow on both axes that must not move.
    push_packet(8'h09, 8'hFF, 8'hFF);
    push_packet(8'h3A, 8'h00, 8'h00);
    push_packet(8'hF7, 8'h12, 8'h34);
    push_packet(8'hCF, 8'hFF, 8'hFF);
    settle();

    // Zero width pins the column to 0, an oversized height caps the row limit.
    write_reg(REG_SCREEN_WIDTH, '0);
    write_reg(REG_SCREEN_HEIGHT, 13'h1FFF);
    write_reg(REG_WHEEL_MODE, 13'd1);
    push_packet(8'h28, 8'h80, 8'h01);

    // Three bytes into a four-byte packet, drop back to three-byte mode: the
    // next byte only closes the packet and is not stored.
    queue_byte(8'h0B);
    queue_byte(8'h7F);
    queue_byte(8'h80);
    settle();
    write_reg(REG_WHEEL_MODE, 13'd0);
    queue_byte(8'h55);

    // Two bytes into a three-byte packet, switch to four-byte mode.
    queue_byte(8'h08);
    queue_byte(8'h01);
    settle();
    write_reg(REG_WHEEL_MODE, 13'd1);
    queue_byte(8'h02);
    queue_byte(8'hAA);

    for (int ph = 0; ph < 8; ph++) begin
      settle();
      case (ph)
        0: begin
          write_reg(REG_SCREEN_WIDTH, 13'd4096);
          write_reg(REG_SCREEN_HEIGHT, 13'd1);
        end
        1: begin
          write_reg(REG_SCREEN_WIDTH, 13'd1);
          write_reg(REG_SCREEN_HEIGHT, 13'd4096);
        end
        default: begin
          write_reg(REG_SCREEN_WIDTH, pick_size());
          write_reg(REG_SCREEN_HEIGHT, pick_size());
        end
      endcase
      write_reg(REG_WHEEL_MODE, 13'($urandom_range(1)));
      if (ph == 2) write_reg(REG_SPARE, 13'($urandom_range(8191)));
      // One phase runs flat out on both sides.
      steady = (ph == 3);
      random_burst(90);
      // Let the decoder run completely dry once in the middle of a phase.
      if (ph == 5) settle();
      random_burst(90);
    end

    settle();
    steady = 1'b0;
    if (pending_reports.size() != 0) begin
      $error("%0d cursor reports never arrived", pending_reports.size());
      mismatches++;
    end
    $display("Sent %0d mouse bytes and checked %0d cursor reports across %0d register writes.",
             bytes_taken, reports_seen, reg_writes);
    $display("Covered dropped headers, misframed runs, overflow, %s",
             "mode switches mid-packet and screen sizes from 0 to 8191.");
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
